/* hdl/ssmd_pkg.sv */
// Package for the multiplexed seven-segment driver.
// Digit type, register indexes and the gfedcba glyph table. No dependencies.
package ssmd_pkg;

    typedef logic [3:0] t_digit;
    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_DIGITS_IN_USE = 2'd0;
    localparam t_cfg_index CFG_COMMON_ANODE  = 2'd1;
    localparam t_cfg_index CFG_DWELL_TICKS   = 2'd2;

    localparam logic [3:0]  RST_DIGITS_IN_USE = 4'd4;
    localparam logic [15:0] RST_DWELL_TICKS   = 16'd10;

    // gfedcba, bit 0 is segment a; codes above nine are blank
    function automatic logic [6:0] f_glyph(input t_digit d);
        logic [6:0] g;
        unique case (d)
            4'd0:    g = 7'h3F;
            4'd1:    g = 7'h06;
            4'd2:    g = 7'h5B;
            4'd3:    g = 7'h4F;
            4'd4:    g = 7'h66;
            4'd5:    g = 7'h6D;
            4'd6:    g = 7'h7D;
            4'd7:    g = 7'h07;
            4'd8:    g = 7'h7F;
            4'd9:    g = 7'h6F;
            default: g = 7'h00;
        endcase
        return g;
    endfunction

endpackage

/* hdl/ssmd_bcd_conv.sv */
// Bit-serial binary to BCD converter (shift and add-3), one bit per cycle.
// Keeps the lowest DIGITS decimal digits. Depends on ssmd_pkg.
module ssmd_bcd_conv #(
    parameter int DIGITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_mag,
    output logic                  o_done,
    output ssmd_pkg::t_digit      o_digits [DIGITS]
);
    import ssmd_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_mag;
    t_digit      r_bcd [DIGITS];
    t_digit      adj   [DIGITS];
    t_digit      n_bcd [DIGITS];

    always_comb begin
        for (int i = 0; i < DIGITS; i++) begin
            adj[i] = (r_bcd[i] >= 4'd5) ? r_bcd[i] + 4'd3 : r_bcd[i];
        end
        n_bcd[0] = {adj[0][2:0], r_mag[31]};
        for (int i = 1; i < DIGITS; i++) begin
            n_bcd[i] = {adj[i][2:0], adj[i-1][3]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            for (int i = 0; i < DIGITS; i++) begin
                r_bcd[i] <= '0;
            end
        end else if (r_busy) begin
            r_mag <= {r_mag[30:0], 1'b0};
            r_bcd <= n_bcd;
        end
    end

    assign o_done   = r_done;
    assign o_digits = r_bcd;

endmodule

/* hdl/seven_segment_mux_driver_core.sv */
// Multiplexed seven-segment driver: digit store, scan/dwell control, output register.
// Path from input transfer to o_m_axis_tvalid: a tick goes through r_pend and the output register,
// a load through the bit-serial BCD conversion, the store update and the output register.
// Input is accepted only in S_IDLE with no result pending; a result waits in the output register.
// Synchronous active-low reset: digits 4, common cathode, dwell 10, store zero, scan 0.
// Depends on ssmd_pkg and ssmd_bcd_conv.
module seven_segment_mux_driver_core #(
    parameter int MAX_DIGIT_COUNT = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    input  logic [31:0]                i_s_axis_tdata,  // value[31:0]
    input  logic                       i_s_axis_tuser,  // mode
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // segment_lines[6:0], digit_lines[14:7], active_digit[17:15], zero pad
    output logic [23:0]                o_m_axis_tdata,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  ssmd_pkg::t_cfg_index       i_cfg_index,
    input  logic [15:0]                i_cfg_data
);
    import ssmd_pkg::*;

    localparam int SW = (MAX_DIGIT_COUNT > 1) ? $clog2(MAX_DIGIT_COUNT) : 1;

    typedef enum logic {S_IDLE, S_CONV} t_state;

    t_state      r_state;
    logic        r_pend;
    logic [3:0]  r_digits_in_use;
    logic        r_common_anode;
    logic [15:0] r_dwell_ticks;
    logic [SW-1:0] r_scan;
    logic [15:0] r_dwell;
    t_digit      r_store [MAX_DIGIT_COUNT];
    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic        in_xfer;
    logic        out_load;
    logic [3:0]  count;
    logic [SW-1:0] eff_scan;
    logic [15:0] dwell_lim;
    logic [15:0] n_dwell;
    logic        advance;
    logic [3:0]  scan_inc;
    logic [SW-1:0] n_scan;
    logic [31:0] mag;
    logic        conv_done;
    t_digit      conv_digits [MAX_DIGIT_COUNT];
    logic [6:0]  segs;
    logic [7:0]  onehot;
    logic [7:0]  lines;

    assign o_s_axis_tready = (r_state == S_IDLE) && !r_pend;
    assign in_xfer         = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign out_load        = r_pend && (!r_out_valid || i_m_axis_tready);

    always_comb begin
        if (r_digits_in_use == 4'd0) begin
            count = 4'd1;
        end else if (r_digits_in_use > 4'(MAX_DIGIT_COUNT)) begin
            count = 4'(MAX_DIGIT_COUNT);
        end else begin
            count = r_digits_in_use;
        end
        eff_scan  = (4'(r_scan) >= count) ? '0 : r_scan;
        dwell_lim = (r_dwell_ticks == 16'd0) ? 16'd1 : r_dwell_ticks;
        n_dwell   = r_dwell + 16'd1;
        advance   = n_dwell >= dwell_lim;
        scan_inc  = 4'(eff_scan) + 4'd1;
        if (!advance) begin
            n_scan = eff_scan;
        end else if (scan_inc >= count) begin
            n_scan = '0;
        end else begin
            n_scan = SW'(scan_inc);
        end
        mag = i_s_axis_tdata[31] ? (32'd0 - i_s_axis_tdata) : i_s_axis_tdata;
    end

    ssmd_bcd_conv #(
        .DIGITS (MAX_DIGIT_COUNT)
    ) u_conv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_xfer && !i_s_axis_tuser),
        .i_mag    (mag),
        .o_done   (conv_done),
        .o_digits (conv_digits)
    );

    always_comb begin
        segs = f_glyph(r_store[r_scan]);
        if (r_common_anode) begin
            segs = ~segs;
        end
        for (int j = 0; j < 8; j++) begin
            onehot[j] = (4'(r_scan) == 4'(j));
        end
        lines = r_common_anode ? onehot : ~onehot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_pend          <= 1'b0;
            r_digits_in_use <= RST_DIGITS_IN_USE;
            r_common_anode  <= 1'b0;
            r_dwell_ticks   <= RST_DWELL_TICKS;
            r_scan          <= '0;
            r_dwell         <= '0;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < MAX_DIGIT_COUNT; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_DIGITS_IN_USE: r_digits_in_use <= i_cfg_data[3:0];
                    CFG_COMMON_ANODE:  r_common_anode  <= i_cfg_data[0];
                    CFG_DWELL_TICKS:   r_dwell_ticks   <= i_cfg_data;
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        if (i_s_axis_tuser) begin
                            r_scan  <= n_scan;
                            r_dwell <= advance ? 16'd0 : n_dwell;
                            r_pend  <= 1'b1;
                        end else begin
                            r_scan  <= eff_scan;
                            r_state <= S_CONV;
                        end
                    end
                end
                S_CONV: begin
                    if (conv_done) begin
                        for (int i = 0; i < MAX_DIGIT_COUNT; i++) begin
                            if (4'(i) < count) begin
                                r_store[i] <= conv_digits[i];
                            end
                        end
                        r_pend  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {6'd0, 3'(r_scan), lines, segs};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
